// File: src/obp_pkg.sv
`timescale 1ns / 1ps
package obp_pkg;

   localparam int LEVELS_DEF = 64;
   localparam int PRICE_W    = 20;
   localparam int QTY_W      = 24;
   localparam int SPREAD_W   = 21;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 120;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: src/obp_mem.sv
`timescale 1ns / 1ps
module obp_mem #(
   parameter int DEPTH = obp_pkg::LEVELS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  obp_pkg::entry_type             wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output obp_pkg::entry_type             rd_data
);
   import obp_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/order_book_price_levels.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata price,amount; tuser opcode,side
// rsp_      out  rsp_tvalid/rsp_tready  tdata best bid, best ask, spread, status
//
// One item at a time: a scan of the selected side's level memory to find the
// price and a free entry, a write-back of at most one entry, a scan of both
// memories for the best levels, an output step once the output register is
// free. After reset a clearing pass over all LEVELS entries zeroes the valid
// bits; no item is taken meanwhile. A stalled result holds in the output register.
module order_book_price_levels #(
   parameter int LEVELS = obp_pkg::LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [19:0] price, [43:20] amount, [47:44] zero
   input  logic [obp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] opcode, [1] side
   input  logic [obp_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] best_bid_valid, [20:1] best_bid_price, [44:21] best_bid_qty,
   // [45] best_ask_valid, [65:46] best_ask_price, [89:66] best_ask_qty,
   // [90] spread_valid, [111:91] spread_ticks, [114:112] status, [119:115] zero
   output logic [obp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import obp_pkg::*;

   localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam logic [IW-1:0] LAST = IW'(LEVELS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_BEST  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic        issue_ff, issue_in;
   logic        rd_vld_ff, rd_last_ff;
   logic [IW-1:0] rd_idx_ff;

   logic               op_ff, side_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   amount_ff;

   logic               hit_ff, hit_in, free_ff, free_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [QTY_W-1:0]   hit_qty_ff, hit_qty_in;

   logic               bb_vld_ff, bb_vld_in, ba_vld_ff, ba_vld_in;
   logic [PRICE_W-1:0] bb_price_ff, bb_price_in, ba_price_ff, ba_price_in;
   logic [QTY_W-1:0]   bb_qty_ff, bb_qty_in, ba_qty_ff, ba_qty_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        req_acc;
   entry_type   bid_rd, ask_rd, sel_rd, wr_data;
   logic        bid_wr, ask_wr;
   logic [IW-1:0] wr_addr;
   logic [QTY_W:0] sum;
   logic [SPREAD_W-1:0] spread;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign sel_rd     = side_ff ? bid_rd : ask_rd;
   assign sum        = {1'b0, hit_qty_ff} + {1'b0, amount_ff};

   obp_mem #(.DEPTH(LEVELS), .AW(IW)) u_bid_mem (
      .clock   (clock),
      .wr_en   (bid_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff),
      .rd_data (bid_rd)
   );

   obp_mem #(.DEPTH(LEVELS), .AW(IW)) u_ask_mem (
      .clock   (clock),
      .wr_en   (ask_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff),
      .rd_data (ask_rd)
   );

   // sequencer, scans and write-back
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      issue_in    = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_qty_in  = hit_qty_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      bb_vld_in   = bb_vld_ff;
      bb_price_in = bb_price_ff;
      bb_qty_in   = bb_qty_ff;
      ba_vld_in   = ba_vld_ff;
      ba_price_in = ba_price_ff;
      ba_qty_in   = ba_qty_ff;
      status_in   = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      bid_wr      = 1'b0;
      ask_wr      = 1'b0;
      wr_addr     = cnt_ff;
      wr_data     = '0;
      spread      = '0;

      // advance the read address while issuing
      if (issue_ff) begin
         cnt_in   = cnt_ff + 1'b1;
         issue_in = (cnt_ff != LAST);
      end

      case (state_ff)
         S_CLEAR: begin
            bid_wr = 1'b1;
            ask_wr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_SCAN;
               cnt_in   = '0;
               issue_in = 1'b1;
               hit_in   = 1'b0;
               free_in  = 1'b0;
            end
         end
         S_SCAN: begin
            // find the price and the lowest free entry
            if (rd_vld_ff) begin
               if (sel_rd.valid && sel_rd.price == price_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_qty_in = sel_rd.qty;
               end
               if (!sel_rd.valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            if (rd_last_ff) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            // modify and write back at most one entry
            status_in    = ST_OK;
            wr_addr      = hit_idx_ff;
            wr_data.valid = 1'b1;
            wr_data.price = price_ff;
            wr_data.qty   = hit_qty_ff;
            if (op_ff == OP_ADD) begin
               if (amount_ff == '0) begin
                  status_in = ST_OK;
               end else if (hit_ff) begin
                  bid_wr = side_ff;
                  ask_wr = ~side_ff;
                  if (sum[QTY_W]) begin
                     wr_data.qty = '1;
                     status_in   = ST_SATURATED;
                  end else begin
                     wr_data.qty = sum[QTY_W-1:0];
                  end
               end else if (free_ff) begin
                  bid_wr      = side_ff;
                  ask_wr      = ~side_ff;
                  wr_addr     = free_idx_ff;
                  wr_data.qty = amount_ff;
               end else begin
                  status_in = ST_FULL;
               end
            end else begin
               if (!hit_ff) begin
                  status_in = ST_ABSENT;
               end else begin
                  bid_wr = side_ff;
                  ask_wr = ~side_ff;
                  if (amount_ff > hit_qty_ff) begin
                     wr_data   = '0;
                     status_in = ST_UNDERFLOW;
                  end else begin
                     wr_data.qty = hit_qty_ff - amount_ff;
                     if (hit_qty_ff == amount_ff) begin
                        wr_data = '0;
                     end
                  end
               end
            end
            state_in  = S_BEST;
            cnt_in    = '0;
            issue_in  = 1'b1;
            bb_vld_in = 1'b0;
            ba_vld_in = 1'b0;
         end
         S_BEST: begin
            // track highest bid and lowest ask
            if (rd_vld_ff) begin
               if (bid_rd.valid && (!bb_vld_ff || bid_rd.price > bb_price_ff)) begin
                  bb_vld_in   = 1'b1;
                  bb_price_in = bid_rd.price;
                  bb_qty_in   = bid_rd.qty;
               end
               if (ask_rd.valid && (!ba_vld_ff || ask_rd.price < ba_price_ff)) begin
                  ba_vld_in   = 1'b1;
                  ba_price_in = ask_rd.price;
                  ba_qty_in   = ask_rd.qty;
               end
            end
            if (rd_last_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               if (bb_vld_ff && ba_vld_ff) begin
                  spread = {1'b0, ba_price_ff} - {1'b0, bb_price_ff};
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, status_ff, spread, (bb_vld_ff & ba_vld_ff),
                  (ba_vld_ff ? ba_qty_ff : {QTY_W{1'b0}}),
                  (ba_vld_ff ? ba_price_ff : {PRICE_W{1'b0}}), ba_vld_ff,
                  (bb_vld_ff ? bb_qty_ff : {QTY_W{1'b0}}),
                  (bb_vld_ff ? bb_price_ff : {PRICE_W{1'b0}}), bb_vld_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= issue_ff;
         rd_last_ff   <= issue_ff && (cnt_ff == LAST);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= cnt_ff;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_qty_ff  <= hit_qty_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      bb_vld_ff   <= bb_vld_in;
      bb_price_ff <= bb_price_in;
      bb_qty_ff   <= bb_qty_in;
      ba_vld_ff   <= ba_vld_in;
      ba_price_ff <= ba_price_in;
      ba_qty_ff   <= ba_qty_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (req_acc) begin
         op_ff     <= req_tuser[0];
         side_ff   <= req_tuser[1];
         price_ff  <= req_tdata[PRICE_W-1:0];
         amount_ff <= req_tdata[PRICE_W+QTY_W-1:PRICE_W];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_upd_to_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |=> (state_ff == S_BEST))
      else $error("write-back not followed by best scan");
   a_last_vld: assert property (@(posedge clock) disable iff (reset)
      rd_last_ff |-> rd_vld_ff)
      else $error("last read without valid data");
   a_acc_scan: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_SCAN && issue_ff && cnt_ff == '0))
      else $error("accepted item did not start a scan");
   a_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[90] == (rsp_tdata[0] & rsp_tdata[45])))
      else $error("spread flag inconsistent with best flags");
`endif

endmodule

// File: verif/tb_order_book_price_levels.sv
`timescale 1ns / 1ps
module tb_order_book_price_levels;
   import obp_pkg::*;

   localparam int NLEV       = LEVELS_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam logic SIDE_ASK = 1'b0;
   localparam logic SIDE_BID = 1'b1;

   // Mirror of both price-level tables; forecasts one book snapshot per item
   class book_scoreboard;
      logic [PRICE_W-1:0]    lvl_price [2][NLEV];
      logic [QTY_W-1:0]      lvl_qty   [2][NLEV];
      bit                    lvl_valid [2][NLEV];
      logic [RSP_DATA_W-1:0] snapshots [$];
      int                    errors;

      function new();
         errors = 0;
         foreach (lvl_valid[s, i]) begin
            lvl_valid[s][i] = 0;
            lvl_price[s][i] = '0;
            lvl_qty[s][i]   = '0;
         end
      endfunction

      function int locate(int s, logic [PRICE_W-1:0] p);
         for (int i = 0; i < NLEV; i++)
            if (lvl_valid[s][i] && lvl_price[s][i] == p) return i;
         return -1;
      endfunction

      function int best_of(int s, bit highest);
         int b;
         b = -1;
         for (int i = 0; i < NLEV; i++) begin
            if (!lvl_valid[s][i]) continue;
            if (b < 0 || (highest ? lvl_price[s][i] > lvl_price[s][b]
                                  : lvl_price[s][i] < lvl_price[s][b]))
               b = i;
         end
         return b;
      endfunction

      // Apply one accepted update and queue the book it should produce
      function void note_update(logic op, logic side, logic [PRICE_W-1:0] p,
                                logic [QTY_W-1:0] amt);
         int s, i, bb, ba;
         logic [STATUS_W-1:0] st;
         logic [QTY_W:0]      sum;
         logic [PRICE_W-1:0]  bp, ap;
         logic [QTY_W-1:0]    bq, aq;
         logic [SPREAD_W-1:0] sp;
         s  = side;
         st = ST_OK;
         i  = locate(s, p);
         if (op == OP_ADD) begin
            if (amt != 0) begin
               if (i < 0) begin
                  for (int k = 0; k < NLEV && i < 0; k++)
                     if (!lvl_valid[s][k]) i = k;
                  if (i < 0) st = ST_FULL;
                  else begin
                     lvl_valid[s][i] = 1;
                     lvl_price[s][i] = p;
                     lvl_qty[s][i]   = amt;
                  end
               end else begin
                  sum = {1'b0, lvl_qty[s][i]} + {1'b0, amt};
                  if (sum[QTY_W]) begin
                     lvl_qty[s][i] = '1;
                     st = ST_SATURATED;
                  end else lvl_qty[s][i] = sum[QTY_W-1:0];
               end
            end
         end else begin
            if (i < 0) st = ST_ABSENT;
            else if (amt > lvl_qty[s][i]) begin
               lvl_valid[s][i] = 0;
               st = ST_UNDERFLOW;
            end else begin
               lvl_qty[s][i] = lvl_qty[s][i] - amt;
               if (lvl_qty[s][i] == 0) lvl_valid[s][i] = 0;
            end
         end
         bb = best_of(SIDE_BID, 1);
         ba = best_of(SIDE_ASK, 0);
         bp = '0; bq = '0; ap = '0; aq = '0; sp = '0;
         if (bb >= 0) begin
            bp = lvl_price[SIDE_BID][bb];
            bq = lvl_qty[SIDE_BID][bb];
         end
         if (ba >= 0) begin
            ap = lvl_price[SIDE_ASK][ba];
            aq = lvl_qty[SIDE_ASK][ba];
         end
         if (bb >= 0 && ba >= 0) sp = {1'b0, ap} - {1'b0, bp};
         snapshots.push_back({5'd0, st, sp, 1'(bb >= 0 && ba >= 0), aq, ap,
                              1'(ba >= 0), bq, bp, 1'(bb >= 0)});
      endfunction

      task report(string field, longint got, longint want);
         errors++;
         $display("t=%0t field %s: got 0x%0h, want 0x%0h", $time, field, got, want);
      endtask

      task compare(string field, longint got, longint want);
         if (got != want) report(field, got, want);
      endtask

      // Compare one delivered book against the oldest forecast
      task check_book(logic [RSP_DATA_W-1:0] got);
         logic [RSP_DATA_W-1:0] w;
         if (snapshots.size() == 0) begin
            report("unexpected item", got[63:0], 0);
            return;
         end
         w = snapshots.pop_front();
         compare("best_bid_valid", got[0],        w[0]);
         compare("best_bid_price", got[20:1],     w[20:1]);
         compare("best_bid_qty",   got[44:21],    w[44:21]);
         compare("best_ask_valid", got[45],       w[45]);
         compare("best_ask_price", got[65:46],    w[65:46]);
         compare("best_ask_qty",   got[89:66],    w[89:66]);
         compare("spread_valid",   got[90],       w[90]);
         compare("spread_ticks",   got[111:91],   w[111:91]);
         compare("status",         got[114:112],  w[114:112]);
         compare("pad",            got[119:115],  w[119:115]);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   book_scoreboard sb;
   int  sender_idle_pct;
   int  rsp_stall_pct;
   int  quiet_cycles;
   int  pool_size;
   logic [PRICE_W-1:0] pool_base;

   order_book_price_levels u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // Random backpressure on the result channel
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Observe both channels, feed the scoreboard, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_update(req_tuser[0], req_tuser[1], req_tdata[19:0], req_tdata[43:20]);
         if (rsp_tvalid && rsp_tready)
            sb.check_book(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Present one item, idle a random gap first, hold until accepted
   task send_update(logic op, logic side, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] amt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, amt, p};
      req_tuser  <= {side, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task random_update();
      logic op, side;
      logic [PRICE_W-1:0] p;
      logic [QTY_W-1:0]   amt;
      int r;
      op   = ($urandom_range(99) < 45) ? OP_REMOVE : OP_ADD;
      side = 1'($urandom_range(1));
      if ($urandom_range(99) < 6) p = PRICE_W'($urandom);
      else p = PRICE_W'(pool_base + $urandom_range(pool_size - 1));
      r = $urandom_range(99);
      if (r < 45)      amt = QTY_W'($urandom_range(1, 100));
      else if (r < 75) amt = QTY_W'($urandom);
      else if (r < 82) amt = '1;
      else if (r < 87) amt = '0;
      else             amt = QTY_W'($urandom_range(1, 5000));
      send_update(op, side, p, amt);
   endtask

   initial begin
      int pools[4];
      pools = '{4, 40, 70, 200};
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      quiet_cycles    = 0;
      pool_size = 40;
      pool_base = 1000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, saturation, exact and oversize removal, absent price
      send_update(OP_ADD,    SIDE_ASK, 20'd100,   24'd5);
      send_update(OP_ADD,    SIDE_BID, 20'd90,    24'd7);
      send_update(OP_ADD,    SIDE_BID, 20'hFFFFF, 24'hFFFFFF);
      send_update(OP_ADD,    SIDE_BID, 20'hFFFFF, 24'd1);
      send_update(OP_REMOVE, SIDE_BID, 20'hFFFFF, 24'hFFFFFF);
      send_update(OP_ADD,    SIDE_ASK, 20'd0,     24'd0);
      send_update(OP_REMOVE, SIDE_ASK, 20'd555,   24'd3);
      send_update(OP_REMOVE, SIDE_ASK, 20'd100,   24'd0);
      send_update(OP_REMOVE, SIDE_ASK, 20'd100,   24'd10);
      send_update(OP_ADD,    SIDE_ASK, 20'd0,     24'd3);
      send_update(OP_ADD,    SIDE_BID, 20'hFFFFF, 24'd2);
      send_update(OP_ADD,    SIDE_ASK, 20'hFFFFF, 24'hFFFFFF);
      send_update(OP_REMOVE, SIDE_BID, 20'hFFFFF, 24'hFFFFFF);
      send_update(OP_REMOVE, SIDE_BID, 20'd90,    24'd7);
      send_update(OP_REMOVE, SIDE_ASK, 20'd0,     24'd3);
      send_update(OP_REMOVE, SIDE_ASK, 20'hFFFFF, 24'hFFFFFE);
      send_update(OP_REMOVE, SIDE_ASK, 20'hFFFFF, 24'd1);

      // Random phases under different idle and stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin sender_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         for (int n = 0; n < 410; n++) begin
            if (n % 60 == 0) begin
               pool_size = pools[$urandom_range(3)];
               case ($urandom_range(3))
                  0: pool_base = '0;
                  1: pool_base = PRICE_W'(20'hFFFFF - pool_size + 1);
                  default: pool_base = PRICE_W'($urandom_range(0, 20'hFFFFF - 256));
               endcase
            end
            random_update();
         end
      end
      req_tvalid <= 1'b0;

      while (sb.snapshots.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
src/obp_pkg.sv
src/obp_mem.sv
src/order_book_price_levels.sv
verif/tb_order_book_price_levels.sv
